// ===== sv/ostt_pkg.sv =====
package ostt_pkg;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int MAX_RESULTS     = 16;

  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 31;
  localparam int OWNER_W    = 32;
  localparam int LISTEN_W   = 16;
  localparam int FRAME_W    = 16;
  localparam int SLOW_W     = 8;
  localparam int KIND_W     = 2;
  localparam int REM_W      = 33;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [SLOW_W-1:0]  SLOW_RESET  = SLOW_W'(1);
  localparam logic [FRAME_W-1:0] CLAMP_RESET = FRAME_W'(500);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOW_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT = 1'b1;

  typedef struct packed {
    logic [REM_W-1:0]    remaining;
    logic [OWNER_W-1:0]  owner;
    logic [LISTEN_W-1:0] listener;
  } ostt_entry_t;

  typedef struct packed {
    logic tick_start;
    logic add_take;
    logic add_go;
    logic sweep_init;
    logic sweep_run;
    logic sweep_end;
    logic flush;
  } ostt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic sweep_done;
    logic hold_valid;
  } ostt_sts_t;

endpackage

// ===== sv/ostt_if.sv =====
interface ostt_req_if;
  import ostt_pkg::*;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [TIME_W-1:0]   current_time;
  logic [DELAY_W-1:0]  delay;
  logic [OWNER_W-1:0]  owner_id;
  logic [LISTEN_W-1:0] listener_handle;

  modport source (output valid, operation, current_time, delay, owner_id, listener_handle,
                  input ready);
  modport sink (input valid, operation, current_time, delay, owner_id, listener_handle,
                output ready);
endinterface

interface ostt_rsp_if;
  import ostt_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [OWNER_W-1:0]  expired_owner;
  logic [LISTEN_W-1:0] expired_listener;
  logic [FRAME_W-1:0]  frame_duration;
  logic                last;

  modport source (output valid, result_kind, expired_owner, expired_listener,
                  frame_duration, last, input ready);
  modport sink (input valid, result_kind, expired_owner, expired_listener,
                frame_duration, last, output ready);
endinterface

interface ostt_cfg_if;
  import ostt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/one_shot_timer_table.sv =====
// Add request: registered on acceptance; the result is loaded into the output register
// once it is free, and the next request is taken after that. Tick request: radix-4
// divider, then a walk over the armed timers through the single-read-port timer list.
// Expiry results stream out during the walk; output stalls hold the walk.
// Reset: table empty, last time 0, slow factor 1, clamp limit 500; no clearing pass.
module one_shot_timer_table #(
  parameter int TIMER_SLOTS = ostt_pkg::DEF_TIMER_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  ostt_req_if.sink   req,
  ostt_rsp_if.source rsp,
  ostt_cfg_if.sink   cfg
);
  import ostt_pkg::*;

  ostt_cmd_t cmd;
  ostt_sts_t sts;

  ostt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_ready     (req.ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  ostt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_current_time    (req.current_time),
    .req_delay           (req.delay),
    .req_owner_id        (req.owner_id),
    .req_listener_handle (req.listener_handle),
    .rsp                 (rsp),
    .cfg                 (cfg)
  );

endmodule

// ===== sv/ostt_div.sv =====
module ostt_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ostt_pkg::TIME_W-1:0]     dividend,
  input  logic [ostt_pkg::SLOW_W-1:0]     divisor,
  output logic                            done,
  output logic                            ovf,
  output logic [ostt_pkg::FRAME_W-1:0]    quot
);
  import ostt_pkg::*;

  localparam int STEPS  = FRAME_W / 2;
  localparam int STEP_W = $clog2(STEPS);
  localparam int X_W    = SLOW_W + 2;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SLOW_W-1:0] part;
  logic [FRAME_W-1:0] lo;

  logic [X_W-1:0]    x, d1, d2, d3;
  logic [1:0]        digit;
  logic [X_W-1:0]    x_next;

  always_comb begin
    x  = {part, lo[FRAME_W-1 -: 2]};
    d1 = {2'b00, divisor};
    d2 = {1'b0, divisor, 1'b0};
    d3 = d1 + d2;
    if (x >= d3) begin
      digit  = 2'd3;
      x_next = x - d3;
    end else if (x >= d2) begin
      digit  = 2'd2;
      x_next = x - d2;
    end else if (x >= d1) begin
      digit  = 2'd1;
      x_next = x - d1;
    end else begin
      digit  = 2'd0;
      x_next = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= dividend[FRAME_W +: SLOW_W];
      lo   <= dividend[FRAME_W-1:0];
      ovf  <= dividend[TIME_W-1 -: FRAME_W] >= {{(FRAME_W-SLOW_W){1'b0}}, divisor};
    end else if (busy) begin
      part <= x_next[SLOW_W-1:0];
      lo   <= {lo[FRAME_W-3:0], digit};
    end
  end

  assign done = !busy;
  assign quot = lo;

endmodule

// ===== sv/ostt_dp.sv =====
module ostt_dp #(
  parameter int TIMER_SLOTS = ostt_pkg::DEF_TIMER_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ostt_pkg::ostt_cmd_t           cmd,
  output ostt_pkg::ostt_sts_t           sts,
  input  logic [ostt_pkg::TIME_W-1:0]   req_current_time,
  input  logic [ostt_pkg::DELAY_W-1:0]  req_delay,
  input  logic [ostt_pkg::OWNER_W-1:0]  req_owner_id,
  input  logic [ostt_pkg::LISTEN_W-1:0] req_listener_handle,
  ostt_rsp_if.source                    rsp,
  ostt_cfg_if.sink                      cfg
);
  import ostt_pkg::*;

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int EW = $clog2(MAX_RESULTS + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(TIMER_SLOTS - 1);
  localparam logic [CW:0]   SLOTS_W  = (CW+1)'(TIMER_SLOTS);
  localparam logic [REM_W-1:0] REM_FLOOR = {1'b1, {(REM_W-1){1'b0}}};

  // configuration and time base
  logic [SLOW_W-1:0]  slow_factor;
  logic [FRAME_W-1:0] clamp_limit;
  logic [TIME_W-1:0]  last_time;

  // held add request
  logic [DELAY_W-1:0]  add_delay;
  logic [OWNER_W-1:0]  add_owner;
  logic [LISTEN_W-1:0] add_listener;

  // timer list, circular, oldest at head
  ostt_entry_t mem [TIMER_SLOTS];
  ostt_entry_t mem_rdata;
  ostt_entry_t mem_wdata;
  logic [IW-1:0] mem_waddr;
  logic          mem_we;
  logic          mem_re;

  logic [IW-1:0] head;
  logic [CW-1:0] count;

  // sweep state
  logic [FRAME_W-1:0] frame;
  logic [IW-1:0]      rd_ptr;
  logic [IW-1:0]      wr_ptr;
  logic [CW-1:0]      rd_left;
  logic [CW-1:0]      kept;
  logic [EW-1:0]      n_emit;
  logic               pend;
  logic               hold_valid;
  logic [OWNER_W-1:0]  hold_owner;
  logic [LISTEN_W-1:0] hold_listener;

  // output register
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [OWNER_W-1:0]  out_owner;
  logic [LISTEN_W-1:0] out_listener;
  logic [FRAME_W-1:0]  out_frame;
  logic                out_last;

  logic [TIME_W-1:0]  elapsed;
  logic [SLOW_W-1:0]  divisor;
  logic               div_done;
  logic               div_ovf;
  logic [FRAME_W-1:0] div_quot;
  logic [FRAME_W-1:0] frame_val;

  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wide;
  logic [IW-1:0] tail;
  logic [IW-1:0] tail_m1;
  logic          full;

  logic [REM_W:0]    diff;
  logic [REM_W-1:0]  new_rem;
  logic              nonpos;
  logic              expire;
  logic              stall;
  logic              run;
  logic              out_free;
  logic              load_out;
  logic              add_write;

  assign elapsed = req_current_time - last_time;
  assign divisor = (slow_factor == '0) ? SLOW_W'(1) : slow_factor;

  ostt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.tick_start),
    .dividend (elapsed),
    .divisor  (divisor),
    .done     (div_done),
    .ovf      (div_ovf),
    .quot     (div_quot)
  );

  assign frame_val = (div_ovf || div_quot > clamp_limit) ? clamp_limit : div_quot;

  always_comb begin
    tail_sum  = {{(CW+1-IW){1'b0}}, head} + {1'b0, count};
    tail_wide = (tail_sum >= SLOTS_W) ? tail_sum - SLOTS_W : tail_sum;
    tail      = tail_wide[IW-1:0];
    tail_m1   = (tail == '0) ? LAST_POS : tail - IW'(1);
  end

  assign full = (count == CW'(TIMER_SLOTS));

  always_comb begin
    diff    = {mem_rdata.remaining[REM_W-1], mem_rdata.remaining}
              - {{(REM_W+1-FRAME_W){1'b0}}, frame};
    new_rem = (diff[REM_W] && !diff[REM_W-1]) ? REM_FLOOR : diff[REM_W-1:0];
    nonpos  = new_rem[REM_W-1] || (new_rem == '0);
  end

  assign out_free  = !out_valid || rsp.ready;
  assign expire    = pend && nonpos && (n_emit < EW'(MAX_RESULTS));
  assign stall     = expire && hold_valid && !out_free;
  assign run       = cmd.sweep_run && !stall;
  assign add_write = cmd.add_go && !full;
  assign load_out  = cmd.add_go || (run && expire && hold_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (cmd.add_take) begin
      add_delay    <= req_delay;
      add_owner    <= req_owner_id;
      add_listener <= req_listener_handle;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr;
    mem_wdata = '{remaining: new_rem, owner: mem_rdata.owner, listener: mem_rdata.listener};
    if (add_write) begin
      mem_we    = 1'b1;
      mem_waddr = tail;
      mem_wdata = '{remaining: {{(REM_W-DELAY_W){1'b0}}, add_delay},
                    owner: add_owner, listener: add_listener};
    end else if (run && pend && !expire) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = run && (rd_left != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_factor <= SLOW_RESET;
      clamp_limit <= CLAMP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SLOW_FACTOR: slow_factor <= cfg.data[SLOW_W-1:0];
        REG_CLAMP_LIMIT: clamp_limit <= cfg.data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (cmd.tick_start) begin
      last_time <= req_current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      rd_left    <= '0;
      kept       <= '0;
      n_emit     <= '0;
      pend       <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (add_write) begin
        count <= count + CW'(1);
      end
      if (cmd.sweep_init) begin
        rd_left    <= count;
        kept       <= '0;
        n_emit     <= '0;
        pend       <= 1'b0;
        hold_valid <= 1'b0;
      end
      if (run) begin
        if (pend && !expire) begin
          kept <= kept + CW'(1);
        end
        if (expire) begin
          hold_valid <= 1'b1;
          n_emit     <= n_emit + EW'(1);
        end
        if (rd_left != '0) begin
          rd_left <= rd_left - CW'(1);
          pend    <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.sweep_end) begin
        head  <= (wr_ptr == LAST_POS) ? '0 : wr_ptr + IW'(1);
        count <= kept;
      end
      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      frame  <= frame_val;
      rd_ptr <= tail_m1;
      wr_ptr <= tail_m1;
    end
    if (run) begin
      if (pend && !expire) begin
        wr_ptr <= (wr_ptr == '0) ? LAST_POS : wr_ptr - IW'(1);
      end
      if (expire) begin
        hold_owner    <= mem_rdata.owner;
        hold_listener <= mem_rdata.listener;
      end
      if (rd_left != '0) begin
        rd_ptr <= (rd_ptr == '0) ? LAST_POS : rd_ptr - IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_go) begin
      out_kind     <= full ? KIND_REJECTED : KIND_ACCEPTED;
      out_owner    <= '0;
      out_listener <= '0;
      out_frame    <= '0;
      out_last     <= 1'b1;
    end else if (load_out) begin
      out_kind     <= KIND_EXPIRED;
      out_owner    <= hold_owner;
      out_listener <= hold_listener;
      out_frame    <= frame;
      out_last     <= cmd.flush;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.result_kind      = out_kind;
  assign rsp.expired_owner    = out_owner;
  assign rsp.expired_listener = out_listener;
  assign rsp.frame_duration   = out_frame;
  assign rsp.last             = out_last;

  assign sts.div_done   = div_done;
  assign sts.out_free   = out_free;
  assign sts.sweep_done = !pend && (rd_left == '0);
  assign sts.hold_valid = hold_valid;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TIMER_SLOTS))
    else $error("timer count exceeds table size");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output register overwritten while held");

  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    n_emit <= EW'(MAX_RESULTS))
    else $error("too many expiries in one tick");

  a_sweep_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_end |=> count <= $past(count))
    else $error("sweep grew the timer list");
`endif

endmodule

// ===== sv/ostt_ctrl.sv =====
module ostt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_operation,
  output logic                req_ready,
  input  ostt_pkg::ostt_sts_t sts,
  output ostt_pkg::ostt_cmd_t cmd
);
  import ostt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_operation == OP_ADD) begin
            cmd.add_take = 1'b1;
            state_next   = ST_ADD;
          end else begin
            cmd.tick_start = 1'b1;
            state_next     = ST_DIV;
          end
        end
      end
      ST_ADD: begin
        if (sts.out_free) begin
          cmd.add_go = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          cmd.sweep_end = 1'b1;
          state_next    = sts.hold_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== tb/sv/timer_table_checker.sv =====
module timer_table_checker (
  input  logic clk,
  input  logic rst,
  ostt_req_if  req,
  ostt_rsp_if  rsp,
  ostt_cfg_if  cfg,
  output int   pending,
  output int   errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import ostt_pkg::*;

  localparam int SLOTS = DEF_TIMER_SLOTS;
  localparam int AGE_W = $clog2(SLOTS);
  localparam longint REM_FLOOR = -64'sd4294967296;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OWNER_W-1:0]  owner;
    logic [LISTEN_W-1:0] listener;
    logic [FRAME_W-1:0]  frame;
    logic                last;
  } timer_result_t;

  logic [SLOW_W-1:0]         slow_q;
  logic [FRAME_W-1:0]        clamp_q;
  logic [TIME_W-1:0]         prev_time;
  logic signed [REM_W-1:0]   t_rem    [SLOTS];
  logic [OWNER_W-1:0]        t_owner  [SLOTS];
  logic [LISTEN_W-1:0]       t_listen [SLOTS];
  logic                      t_armed  [SLOTS];
  logic [AGE_W-1:0]          t_age    [SLOTS];
  timer_result_t             result_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void arm_timer(input logic [DELAY_W-1:0] dly,
                                    input logic [OWNER_W-1:0] own,
                                    input logic [LISTEN_W-1:0] lis);
    int slot;
    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (!t_armed[i] && slot < 0) slot = i;
    if (slot < 0) begin
      result_q.push_back('{KIND_REJECTED, '0, '0, '0, 1'b1});
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (t_armed[i]) t_age[i] = t_age[i] + 1'b1;
      t_rem[slot]    = REM_W'(dly);
      t_owner[slot]  = own;
      t_listen[slot] = lis;
      t_age[slot]    = '0;
      t_armed[slot]  = 1'b1;
      result_q.push_back('{KIND_ACCEPTED, '0, '0, '0, 1'b1});
    end
  endfunction

  function automatic void advance_timers(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  quotient;
    logic [FRAME_W-1:0] frame;
    logic [AGE_W-1:0]   gone_age;
    longint             left;
    int                 pick;
    int                 count;
    elapsed  = now - prev_time;
    quotient = elapsed / ((slow_q == '0) ? TIME_W'(1) : TIME_W'(slow_q));
    frame    = (quotient > clamp_q) ? clamp_q : quotient[FRAME_W-1:0];
    prev_time = now;
    for (int i = 0; i < SLOTS; i++) begin
      if (t_armed[i]) begin
        left = longint'(t_rem[i]) - longint'(frame);
        if (left < REM_FLOOR) left = REM_FLOOR;
        t_rem[i] = left[REM_W-1:0];
      end
    end
    count = 0;
    while (count < MAX_RESULTS) begin
      pick = -1;
      for (int i = 0; i < SLOTS; i++)
        if (t_armed[i] && t_rem[i] <= 0 && (pick < 0 || t_age[i] < t_age[pick]))
          pick = i;
      if (pick < 0) break;
      result_q.push_back('{KIND_EXPIRED, t_owner[pick], t_listen[pick], frame, 1'b0});
      count++;
      gone_age       = t_age[pick];
      t_armed[pick]  = 1'b0;
      t_age[pick]    = '0;
      for (int i = 0; i < SLOTS; i++)
        if (t_armed[i] && t_age[i] > gone_age) t_age[i] = t_age[i] - 1'b1;
    end
    if (count > 0) result_q[result_q.size()-1].last = 1'b1;
  endfunction

  function automatic void compare_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t chk: %s expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (rst) begin
      slow_q    = SLOW_RESET;
      clamp_q   = CLAMP_RESET;
      prev_time = '0;
      for (int i = 0; i < SLOTS; i++) begin
        t_armed[i] = 1'b0;
        t_age[i]   = '0;
      end
      result_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.result_kind, rsp.expired_owner, rsp.expired_listener,
                rsp.frame_duration, rsp.last};
        if (result_q.size() == 0) begin
          $display("%0t chk: result with nothing expected, kind %0d owner %0h listener %0h",
                   $time, got.kind, got.owner, got.listener);
          errors++;
        end else begin
          want = result_q.pop_front();
          compare_field("result_kind", 32'(want.kind), 32'(got.kind));
          compare_field("expired_owner", want.owner, got.owner);
          compare_field("expired_listener", 32'(want.listener), 32'(got.listener));
          compare_field("frame_duration", 32'(want.frame), 32'(got.frame));
          compare_field("last", 32'(want.last), 32'(got.last));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SLOW_FACTOR: slow_q = cfg.data[SLOW_W-1:0];
          REG_CLAMP_LIMIT: clamp_q = cfg.data[FRAME_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.operation == OP_ADD) arm_timer(req.delay, req.owner_id, req.listener_handle);
        else advance_timers(req.current_time);
      end
    end
    pending <= result_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ostt_pkg::*;

  typedef enum {DRAIN_FULL, DRAIN_CHOPPY, DRAIN_SLOW} drain_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  int                pending;
  int                errors;
  int                burst_left = 0;
  drain_mode_t       drain_mode = DRAIN_FULL;
  int                drain_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  ostt_req_if req_ch ();
  ostt_rsp_if rsp_ch ();
  ostt_cfg_if cfg_ch ();

  one_shot_timer_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  timer_table_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg     (cfg_ch),
    .pending (pending),
    .errors  (errors)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (drain_left == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 2));
      drain_left <= $urandom_range(40, 300);
    end else begin
      drain_left <= drain_left - 1;
    end
    case (drain_mode)
      DRAIN_FULL:   rsp_ch.ready <= 1'b1;
      DRAIN_CHOPPY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      default:      rsp_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_request(input logic op, input logic [TIME_W-1:0] at,
                              input logic [DELAY_W-1:0] dly, input logic [OWNER_W-1:0] own,
                              input logic [LISTEN_W-1:0] lis);
    int gap;
    req_ch.valid           <= 1'b1;
    req_ch.operation       <= op;
    req_ch.current_time    <= at;
    req_ch.delay           <= dly;
    req_ch.owner_id        <= own;
    req_ch.listener_handle <= lis;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic tick_at(input logic [TIME_W-1:0] at);
    send_request(OP_TICK, at, DELAY_W'($urandom), $urandom, LISTEN_W'($urandom));
  endtask

  task automatic add_timer(input logic [DELAY_W-1:0] dly, input logic [OWNER_W-1:0] own,
                           input logic [LISTEN_W-1:0] lis);
    send_request(OP_ADD, $urandom, dly, own, lis);
  endtask

  // drop valid, drain every result, then let the walk finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int divisor, input int add_pct);
    logic [TIME_W-1:0]  step;
    logic [DELAY_W-1:0] dly;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1, 100) <= add_pct) begin
        case ($urandom_range(0, 9))
          0:       dly = '0;
          1:       dly = DELAY_W'($urandom);
          default: dly = DELAY_W'($urandom_range(0, 1500));
        endcase
        add_timer(dly, $urandom, LISTEN_W'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       step = $urandom;
          1, 2:    step = $urandom_range(0, 40);
          default: step = $urandom_range(0, 700) * divisor;
        endcase
        clock_ms = clock_ms + step;
        tick_at(clock_ms);
      end
    end
  endtask

  initial begin
    logic [SLOW_W-1:0]  slow_set  [6];
    logic [FRAME_W-1:0] clamp_set [6];
    req_ch.valid           = 1'b0;
    req_ch.operation       = OP_TICK;
    req_ch.current_time    = '0;
    req_ch.delay           = '0;
    req_ch.owner_id        = '0;
    req_ch.listener_handle = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_SLOW_FACTOR;
    cfg_ch.data            = '0;
    rsp_ch.ready           = 1'b0;
    slow_set  = '{8'd0, 8'd255, 8'd255, 8'd3, 8'd1, 8'd1};
    clamp_set = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd500};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tick_at(32'd0);
    add_timer('0, '0, '0);
    add_timer({DELAY_W{1'b1}}, {OWNER_W{1'b1}}, {LISTEN_W{1'b1}});
    add_timer(DELAY_W'(100), $urandom, LISTEN_W'($urandom));
    tick_at(32'd50);
    tick_at(32'd200);
    repeat (15) add_timer(DELAY_W'($urandom_range(0, 400)), $urandom, LISTEN_W'($urandom));
    add_timer(DELAY_W'(7), $urandom, LISTEN_W'($urandom));
    tick_at(32'd1200);
    tick_at(32'hFFFF_FFF0);
    tick_at(32'h0000_0010);
    clock_ms = 32'h0000_0010;
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 4) begin
        slow_set[p]  = SLOW_W'($urandom_range(1, 255));
        clamp_set[p] = FRAME_W'($urandom);
      end
      write_reg(REG_SLOW_FACTOR, {8'($urandom), slow_set[p]});
      write_reg(REG_CLAMP_LIMIT, clamp_set[p]);
      run_phase(42, (slow_set[p] == '0) ? 1 : int'(slow_set[p]), 40 + 5 * p);
      settle();
    end

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
